// ===== src/gpt_header_validator_unit_assert.svh =====
// Assertion macros used by the GPT header validator top level.
`ifndef GPT_HEADER_VALIDATOR_UNIT_ASSERT_SVH
`define GPT_HEADER_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define GPTHV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define GPTHV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gpthv_pkg.sv =====
// Types, constants and CRC helpers for the GPT header validator.
package gpthv_pkg;

  localparam int unsigned SECTOR_BYTES  = 512;
  localparam int unsigned HDR_MIN_BYTES = 92;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] IDX_MAX       = 32'hFFFF_FFFF;

  // Header field offsets
  localparam logic [31:0] OFS_SIG_END   = 32'h08;
  localparam logic [31:0] OFS_HDR_SIZE  = 32'h0C;
  localparam logic [31:0] OFS_HDR_CRC   = 32'h10;
  localparam logic [31:0] OFS_OWN_LBA   = 32'h18;
  localparam logic [31:0] OFS_ARR_LBA   = 32'h48;
  localparam logic [31:0] OFS_ENT_CNT   = 32'h50;
  localparam logic [31:0] OFS_ENT_SIZE  = 32'h54;
  localparam logic [31:0] OFS_ARR_CRC   = 32'h58;

  // "EFI PART"
  localparam logic [7:0] SIG_BYTES [8] = '{8'h45, 8'h46, 8'h49, 8'h20,
                                           8'h50, 8'h41, 8'h52, 8'h54};

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIG   = 3'd1,
    ST_HDR_CRC   = 3'd2,
    ST_LBA       = 3'd3,
    ST_ARRAY_CRC = 3'd4,
    ST_HDR_SIZE  = 3'd5,
    ST_SEQ       = 3'd6
  } status_t;

  typedef enum logic {
    REQ_HEADER = 1'b0,
    REQ_ARRAY  = 1'b1
  } req_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        final_res;
    logic [63:0] entry_array_lba;
    logic [31:0] entry_array_bytes;
  } out_item_t;

  // Result handed from the core to the output stage
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] put_byte32(input logic [31:0] v, input logic [1:0] lane,
                                             input logic [7:0] b);
    logic [31:0] r;
    r = v;
    r[lane*8 +: 8] = b;
    return r;
  endfunction

  function automatic logic [63:0] put_byte64(input logic [63:0] v, input logic [2:0] lane,
                                             input logic [7:0] b);
    logic [63:0] r;
    r = v;
    r[lane*8 +: 8] = b;
    return r;
  endfunction

endpackage

// ===== src/gpthv_core.sv =====
// Per-byte state update, field capture, CRC and verdict logic.
module gpthv_core
  import gpthv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [63:0] cfg_lba,
  output res_t        res
);

  logic [63:0] expected_lba;
  logic [31:0] byte_index, byte_index_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] stored_header_crc, stored_header_crc_next;
  logic [31:0] header_size, header_size_next;
  logic [63:0] own_lba, own_lba_next;
  logic [63:0] array_lba, array_lba_next;
  logic [31:0] entry_count, entry_count_next;
  logic [31:0] entry_size, entry_size_next;
  logic [31:0] stored_array_crc, stored_array_crc_next;
  logic        signature_ok, signature_ok_next;
  logic        awaiting_array, awaiting_array_next;
  logic [31:0] array_bytes;

  logic [31:0] idx_inc;
  logic [31:0] crc_new;
  logic [7:0]  fed;
  logic        in_hdr;
  status_t     verdict;

  function automatic logic in_field(input logic [31:0] idx, input logic [31:0] base,
                                    input logic [31:0] len);
    return (idx >= base) && (idx < base + len);
  endfunction

  assign idx_inc = (byte_index == IDX_MAX) ? byte_index : byte_index + 32'd1;
  assign in_hdr  = byte_index < 32'(SECTOR_BYTES);

  always_comb begin
    byte_index_next        = byte_index;
    running_crc_next       = running_crc;
    stored_header_crc_next = stored_header_crc;
    header_size_next       = header_size;
    own_lba_next           = own_lba;
    array_lba_next         = array_lba;
    entry_count_next       = entry_count;
    entry_size_next        = entry_size;
    stored_array_crc_next  = stored_array_crc;
    signature_ok_next      = signature_ok;
    awaiting_array_next    = awaiting_array;
    res                    = '0;
    fed                    = in_item.data_byte;
    crc_new                = running_crc;
    verdict                = ST_OK;

    if (in_fire) begin
      if (in_item.req_type == REQ_HEADER) begin
        if (awaiting_array) begin
          // header byte while the array is expected: drop and restart
          res.valid           = 1'b1;
          res.item.status     = ST_SEQ;
          res.item.final_res  = 1'b1;
          byte_index_next     = '0;
          running_crc_next    = CRC_INIT;
          signature_ok_next   = 1'b1;
          awaiting_array_next = 1'b0;
        end else begin
          if (in_hdr) begin
            if (byte_index < OFS_SIG_END &&
                in_item.data_byte != SIG_BYTES[byte_index[2:0]])
              signature_ok_next = 1'b0;
            if (in_field(byte_index, OFS_HDR_SIZE, 32'd4))
              header_size_next = put_byte32(header_size, byte_index[1:0], in_item.data_byte);
            if (in_field(byte_index, OFS_HDR_CRC, 32'd4)) begin
              stored_header_crc_next = put_byte32(stored_header_crc, byte_index[1:0],
                                                  in_item.data_byte);
              fed = 8'd0;
            end
            if (in_field(byte_index, OFS_OWN_LBA, 32'd8))
              own_lba_next = put_byte64(own_lba, byte_index[2:0], in_item.data_byte);
            if (in_field(byte_index, OFS_ARR_LBA, 32'd8))
              array_lba_next = put_byte64(array_lba, byte_index[2:0], in_item.data_byte);
            if (in_field(byte_index, OFS_ENT_CNT, 32'd4))
              entry_count_next = put_byte32(entry_count, byte_index[1:0], in_item.data_byte);
            if (in_field(byte_index, OFS_ENT_SIZE, 32'd4))
              entry_size_next = put_byte32(entry_size, byte_index[1:0], in_item.data_byte);
            if (in_field(byte_index, OFS_ARR_CRC, 32'd4))
              stored_array_crc_next = put_byte32(stored_array_crc, byte_index[1:0],
                                                 in_item.data_byte);
            if (byte_index < OFS_HDR_CRC || byte_index < header_size)
              crc_new = crc_byte(running_crc, fed);
          end
          running_crc_next = crc_new;
          byte_index_next  = idx_inc;

          if (in_item.last) begin
            // fields are all captured well before the last byte of a full sector
            if (idx_inc != 32'(SECTOR_BYTES))           verdict = ST_SEQ;
            else if (!signature_ok)                     verdict = ST_BAD_SIG;
            else if (header_size > 32'(SECTOR_BYTES))   verdict = ST_HDR_SIZE;
            else if (header_size < 32'(HDR_MIN_BYTES))  verdict = ST_SEQ;
            else if (~crc_new != stored_header_crc)     verdict = ST_HDR_CRC;
            else if (own_lba != expected_lba)           verdict = ST_LBA;
            else                                        verdict = ST_OK;

            byte_index_next     = '0;
            running_crc_next    = CRC_INIT;
            signature_ok_next   = 1'b1;
            awaiting_array_next = 1'b0;
            res.valid           = 1'b1;
            res.item.final_res  = 1'b1;
            res.item.status     = verdict;
            if (verdict == ST_OK) begin
              res.item.entry_array_lba   = array_lba;
              res.item.entry_array_bytes = array_bytes;
              if (array_bytes == 32'd0) begin
                // empty array: its CRC is zero
                res.item.status = (stored_array_crc == 32'd0) ? ST_OK : ST_ARRAY_CRC;
              end else begin
                res.item.final_res  = 1'b0;
                awaiting_array_next = 1'b1;
              end
            end
          end
        end
      end else begin
        if (!awaiting_array) begin
          res.valid          = 1'b1;
          res.item.status    = ST_SEQ;
          res.item.final_res = 1'b1;
          byte_index_next    = '0;
          running_crc_next   = CRC_INIT;
          signature_ok_next  = 1'b1;
        end else begin
          crc_new          = crc_byte(running_crc, in_item.data_byte);
          running_crc_next = crc_new;
          byte_index_next  = idx_inc;
          if (in_item.last) begin
            if (idx_inc != array_bytes)                verdict = ST_SEQ;
            else if (~crc_new != stored_array_crc)     verdict = ST_ARRAY_CRC;
            else                                       verdict = ST_OK;
            res.valid          = 1'b1;
            res.item.status    = verdict;
            res.item.final_res = 1'b1;
            if (verdict != ST_SEQ) begin
              res.item.entry_array_lba   = array_lba;
              res.item.entry_array_bytes = array_bytes;
            end
            byte_index_next     = '0;
            running_crc_next    = CRC_INIT;
            signature_ok_next   = 1'b1;
            awaiting_array_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_lba      <= 64'd1;
      byte_index        <= '0;
      running_crc       <= CRC_INIT;
      stored_header_crc <= '0;
      header_size       <= '0;
      own_lba           <= '0;
      array_lba         <= '0;
      entry_count       <= '0;
      entry_size        <= '0;
      stored_array_crc  <= '0;
      signature_ok      <= 1'b1;
      awaiting_array    <= 1'b0;
    end else begin
      if (cfg_we)
        expected_lba <= cfg_lba;
      byte_index        <= byte_index_next;
      running_crc       <= running_crc_next;
      stored_header_crc <= stored_header_crc_next;
      header_size       <= header_size_next;
      own_lba           <= own_lba_next;
      array_lba         <= array_lba_next;
      entry_count       <= entry_count_next;
      entry_size        <= entry_size_next;
      stored_array_crc  <= stored_array_crc_next;
      signature_ok      <= signature_ok_next;
      awaiting_array    <= awaiting_array_next;
    end
  end

  // Array length, registered; count and size settle hundreds of bytes before use
  always_ff @(posedge clk) begin
    array_bytes <= 32'(entry_count * entry_size);
  end

endmodule

// ===== src/gpthv_out_stage.sv =====
// Output register holding one result until the sink takes it.
module gpthv_out_stage
  import gpthv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_item,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic out_valid_next;

  // a new item may enter while the held result leaves in the same cycle
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load)
      out_valid_next = 1'b1;
    else if (out_ready)
      out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load)
      out_data <= load_item;
  end

endmodule

// ===== src/gpt_header_validator_unit.sv =====
// Top level of the GPT header validator: core logic plus output register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  in       | sink      | in_valid/in_ready  | in_data: req_type, data_byte, last
//  out      | source    | out_valid/out_ready| out_data: status, final_res, lba, bytes
//  cfg      | sink      | cfg_valid/cfg_ready| cfg_data: expected_lba
//
// One byte per cycle while in_ready is high; a result appears in out_data in the cycle
// after the segment's last byte; CRC update and verdict are combinational in the core.
// Synchronous active-high rst; expected_lba resets to 1, cfg_ready is always high.
// in_ready drops only while a result is held and out_ready is low.
`include "gpt_header_validator_unit_assert.svh"

module gpt_header_validator_unit
  import gpthv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic in_fire;
  res_t res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  gpthv_core u_core (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_item (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_lba (cfg_data),
    .res     (res)
  );

  gpthv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire && res.valid),
    .load_item (res.item),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `GPTHV_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready,
                     "input accepted while a result is stalled")
  `GPTHV_ASSERT_NEXT(a_result_lands, in_fire && res.valid, out_valid,
                     "result of an accepted transaction was lost")
  `GPTHV_ASSERT_SAME(a_pending_is_ok, out_valid && !out_data.final_res,
                     out_data.status == ST_OK, "non-final verdict with a failing status")
  `GPTHV_ASSERT_SAME(a_fields_zero,
                     out_valid && out_data.status != ST_OK &&
                     out_data.status != ST_ARRAY_CRC,
                     out_data.entry_array_lba == 64'd0 &&
                     out_data.entry_array_bytes == 32'd0,
                     "fields reported with an early failure status")
  `GPTHV_ASSERT_SAME(a_seq_is_final, out_valid && out_data.status == ST_SEQ,
                     out_data.final_res, "sequence error not final")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the GPT header validator: header and entry-array streams.
module tb_top;
  import gpthv_pkg::*;

  // Tracks the validator state and queues the verdicts it must emit
  class verdict_board;
    logic [63:0] want_lba;
    logic [31:0] idx;
    logic [31:0] crc;
    logic [31:0] hdr_crc;
    logic [31:0] hdr_size;
    logic [31:0] ent_cnt;
    logic [31:0] ent_sz;
    logic [31:0] arr_crc;
    logic [63:0] self_lba;
    logic [63:0] arr_lba;
    bit sig_good;
    bit in_array;
    out_item_t pending_verdicts[$];
    int errors;

    function new();
      errors = 0;
      want_lba = 64'd1;
      hdr_crc = '0;
      hdr_size = '0;
      ent_cnt = '0;
      ent_sz = '0;
      arr_crc = '0;
      self_lba = '0;
      arr_lba = '0;
      back_to_idle();
    endfunction

    static function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
      for (int i = 0; i < 8; i++) begin
        if (c[0] ^ b[i]) c = (c >> 1) ^ 32'hEDB8_8320;
        else c = c >> 1;
      end
      return c;
    endfunction

    function void back_to_idle();
      idx = '0;
      crc = '1;
      sig_good = 1'b1;
      in_array = 1'b0;
    endfunction

    function logic [31:0] array_len();
      return ent_cnt * ent_sz;
    endfunction

    function void queue_verdict(status_t st, logic fin, bit with_fields);
      out_item_t v;
      v.status = st;
      v.final_res = fin;
      v.entry_array_lba = with_fields ? arr_lba : 64'd0;
      v.entry_array_bytes = with_fields ? array_len() : 32'd0;
      pending_verdicts.push_back(v);
    endfunction

    function void capture_header(logic [31:0] i, logic [7:0] b);
      logic [7:0] fed;
      fed = b;
      if (i < OFS_SIG_END && b != SIG_BYTES[i[2:0]]) sig_good = 1'b0;
      if (i >= OFS_HDR_SIZE && i < OFS_HDR_CRC) hdr_size[8*i[1:0] +: 8] = b;
      if (i >= OFS_HDR_CRC && i < OFS_HDR_CRC + 4) begin
        hdr_crc[8*i[1:0] +: 8] = b;
        fed = 8'h00;  // stored CRC field is hashed as zero
      end
      if (i >= OFS_OWN_LBA && i < OFS_OWN_LBA + 8) self_lba[8*i[2:0] +: 8] = b;
      if (i >= OFS_ARR_LBA && i < OFS_ENT_CNT) arr_lba[8*i[2:0] +: 8] = b;
      if (i >= OFS_ENT_CNT && i < OFS_ENT_SIZE) ent_cnt[8*i[1:0] +: 8] = b;
      if (i >= OFS_ENT_SIZE && i < OFS_ARR_CRC) ent_sz[8*i[1:0] +: 8] = b;
      if (i >= OFS_ARR_CRC && i < OFS_ARR_CRC + 4) arr_crc[8*i[1:0] +: 8] = b;
      if (i < OFS_HDR_CRC || i < hdr_size) crc = crc32_step(crc, fed);
    endfunction

    function void take_byte(in_item_t it);
      status_t st;
      if (it.req_type == REQ_HEADER) begin
        if (in_array) begin
          back_to_idle();
          queue_verdict(ST_SEQ, 1'b1, 0);
          return;
        end
        if (idx < SECTOR_BYTES) capture_header(idx, it.data_byte);
        if (idx != '1) idx++;
        if (!it.last) return;
        if (idx != SECTOR_BYTES) st = ST_SEQ;
        else if (!sig_good) st = ST_BAD_SIG;
        else if (hdr_size > SECTOR_BYTES) st = ST_HDR_SIZE;
        else if (hdr_size < HDR_MIN_BYTES) st = ST_SEQ;
        else if (~crc != hdr_crc) st = ST_HDR_CRC;
        else if (self_lba != want_lba) st = ST_LBA;
        else st = ST_OK;
        back_to_idle();
        if (st != ST_OK) queue_verdict(st, 1'b1, 0);
        else if (array_len() != 0) begin
          in_array = 1'b1;
          queue_verdict(ST_OK, 1'b0, 1);
        end else if (arr_crc == 0) queue_verdict(ST_OK, 1'b1, 1);
        else queue_verdict(ST_ARRAY_CRC, 1'b1, 1);
        return;
      end
      if (!in_array) begin
        back_to_idle();
        queue_verdict(ST_SEQ, 1'b1, 0);
        return;
      end
      crc = crc32_step(crc, it.data_byte);
      if (idx != '1) idx++;
      if (!it.last) return;
      if (idx != array_len()) st = ST_SEQ;
      else if (~crc != arr_crc) st = ST_ARRAY_CRC;
      else st = ST_OK;
      back_to_idle();
      queue_verdict(st, 1'b1, st != ST_SEQ);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task match_verdict(out_item_t got);
      out_item_t w;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result with none pending, status %0d", got.status));
        return;
      end
      w = pending_verdicts.pop_front();
      if (got.status !== w.status)
        report($sformatf("status got %0d want %0d", got.status, w.status));
      if (got.final_res !== w.final_res)
        report($sformatf("final_res got %0b want %0b", got.final_res, w.final_res));
      if (got.entry_array_lba !== w.entry_array_lba)
        report($sformatf("entry_array_lba got %0h want %0h",
                         got.entry_array_lba, w.entry_array_lba));
      if (got.entry_array_bytes !== w.entry_array_bytes)
        report($sformatf("entry_array_bytes got %0h want %0h",
                         got.entry_array_bytes, w.entry_array_bytes));
    endtask
  endclass

  typedef struct {
    bit          bad_sig;
    bit          bad_hcrc;
    bit          bad_acrc;
    logic [31:0] hsize;
    logic [31:0] cnt;
    logic [31:0] esz;
    logic [63:0] lba;
    int          hdr_len;
    int          arr_delta;
    int          cut_at;
  } hdr_plan_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  verdict_board sb = new();
  int sent_items = 0;
  bit tx_calm = 1'b0;
  bit hold_long = 1'b0;
  bit holding = 1'b0;

  gpt_header_validator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.match_verdict(out_data);
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int n;
    wait (rst == 1'b0);
    forever begin
      if (hold_long) begin
        n = 300;
        hold_long = 1'b0;
        holding = 1'b1;
      end else begin
        n = pick_gap($urandom_range(0, 4) == 0);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      holding = 1'b0;
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 80) repeat ($urandom_range(1, 8)) @(posedge clk);
      else repeat ($urandom_range(20, 60)) @(posedge clk);
    end
  end

  initial begin
    #60_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic send_item(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(it);
    sent_items++;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_raw(input req_t kind, input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.req_type = kind;
      it.data_byte = 8'($urandom);
      it.last = (i == n - 1);
      send_item(it);
    end
  endtask

  // Stop offering, wait for every pending verdict, then let the pipeline settle
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_lba(input logic [63:0] v);
    settle(4);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.want_lba = v;
  endtask

  function automatic hdr_plan_t plain_plan();
    hdr_plan_t p;
    p.bad_sig = 0;
    p.bad_hcrc = 0;
    p.bad_acrc = 0;
    p.hsize = HDR_MIN_BYTES;
    p.cnt = 32'd2;
    p.esz = 32'd8;
    p.lba = sb.want_lba;
    p.hdr_len = SECTOR_BYTES;
    p.arr_delta = 0;
    p.cut_at = -1;
    return p;
  endfunction

  // Build one header sector per plan, send it, then the entry array if one is due
  task automatic run_gpt(input hdr_plan_t p);
    logic [7:0] img [SECTOR_BYTES];
    logic [7:0] arr [$];
    logic [31:0] len;
    logic [31:0] c;
    int total;
    int n;
    in_item_t it;
    len = p.cnt * p.esz;
    total = int'(len) + p.arr_delta;
    for (int i = 0; i < SECTOR_BYTES; i++) img[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) img[i] = SIG_BYTES[i];
    if (p.bad_sig) img[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < 4; i++) begin
      img[OFS_HDR_SIZE + i] = p.hsize[8*i +: 8];
      img[OFS_HDR_CRC + i] = 8'h00;
      img[OFS_ENT_CNT + i] = p.cnt[8*i +: 8];
      img[OFS_ENT_SIZE + i] = p.esz[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) img[OFS_OWN_LBA + i] = p.lba[8*i +: 8];
    n = (total > int'(len)) ? total : int'(len);
    for (int i = 0; i < n; i++) arr.push_back(8'($urandom));
    c = '1;
    for (int i = 0; i < int'(len); i++) c = verdict_board::crc32_step(c, arr[i]);
    c = ~c;
    if (p.bad_acrc) c ^= 32'(1) << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) img[OFS_ARR_CRC + i] = c[8*i +: 8];
    n = (p.hsize > SECTOR_BYTES) ? SECTOR_BYTES : int'(p.hsize);
    if (n < 16) n = 16;
    c = '1;
    for (int i = 0; i < n; i++) c = verdict_board::crc32_step(c, img[i]);
    c = ~c;
    if (p.bad_hcrc) c ^= 32'(1) << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) img[OFS_HDR_CRC + i] = c[8*i +: 8];
    for (int i = 0; i < p.hdr_len; i++) begin
      it.req_type = REQ_HEADER;
      it.data_byte = (i < SECTOR_BYTES) ? img[i] : 8'($urandom);
      it.last = (i == p.hdr_len - 1);
      send_item(it);
    end
    if (!sb.in_array) return;
    if (p.cut_at >= 0 && p.cut_at < int'(len)) begin
      for (int i = 0; i < p.cut_at; i++) begin
        it.req_type = REQ_ARRAY;
        it.data_byte = arr[i];
        it.last = 1'b0;
        send_item(it);
      end
      // header byte while the array is still owed
      it.req_type = REQ_HEADER;
      it.data_byte = 8'($urandom);
      it.last = 1'($urandom);
      send_item(it);
      return;
    end
    if (total < 1) total = 1;
    for (int i = 0; i < total; i++) begin
      it.req_type = REQ_ARRAY;
      it.data_byte = arr[i];
      it.last = (i == total - 1);
      send_item(it);
    end
  endtask

  task automatic random_sequence();
    hdr_plan_t p;
    int r;
    int k;
    logic [31:0] len;
    tx_calm = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 85) begin
      p = plain_plan();
      p.bad_sig = ($urandom_range(0, 19) == 0);
      k = $urandom_range(0, 99);
      if (k < 5) p.hsize = $urandom_range(513, 32'hFFFF_FFFF);
      else if (k < 10) p.hsize = $urandom_range(0, 91);
      else if (k < 15) p.hsize = HDR_MIN_BYTES;
      else if (k < 20) p.hsize = SECTOR_BYTES;
      else p.hsize = $urandom_range(92, 512);
      p.bad_hcrc = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 99) < 7) p.lba = {$urandom, $urandom};
      if ($urandom_range(0, 6) == 0) begin
        p.cnt = $urandom_range(0, 1) ? 32'd0 : $urandom;
        p.esz = (p.cnt == 0) ? $urandom : 32'd0;
      end else begin
        p.cnt = $urandom_range(1, 4);
        p.esz = ($urandom_range(0, 3) == 0) ? 32'd128 : $urandom_range(1, 32);
      end
      p.bad_acrc = ($urandom_range(0, 11) == 0);
      if ($urandom_range(0, 15) == 0) p.hdr_len = SECTOR_BYTES + $urandom_range(0, 40) - 20;
      k = $urandom_range(0, 19);
      if (k == 0) p.arr_delta = $urandom_range(1, 3);
      else if (k == 1) p.arr_delta = -int'($urandom_range(1, 3));
      len = p.cnt * p.esz;
      if (r >= 75 && len != 0) p.cut_at = $urandom_range(0, int'(len) - 1);
      run_gpt(p);
    end else if (r < 93) begin
      send_raw(REQ_HEADER, $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(513, 560));
    end else begin
      send_raw(REQ_ARRAY, $urandom_range(1, 3));
    end
  endtask

  initial begin : main
    hdr_plan_t p;
    int base_items;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases, expected_lba still at its reset value
    send_raw(REQ_ARRAY, 1);
    send_raw(REQ_HEADER, 3);
    p = plain_plan(); run_gpt(p);
    p = plain_plan(); p.cut_at = 5; run_gpt(p);
    p = plain_plan(); p.bad_sig = 1; run_gpt(p);
    p = plain_plan(); p.hsize = 32'hFFFF_FFFF; run_gpt(p);
    p = plain_plan(); p.hsize = HDR_MIN_BYTES - 1; run_gpt(p);
    p = plain_plan(); p.hsize = SECTOR_BYTES; run_gpt(p);
    p = plain_plan(); p.hsize = SECTOR_BYTES; p.bad_hcrc = 1; run_gpt(p);
    p = plain_plan(); p.lba = 64'd2; run_gpt(p);
    p = plain_plan(); p.cnt = 0; run_gpt(p);
    p = plain_plan(); p.esz = 0; p.bad_acrc = 1; run_gpt(p);
    // count times size wraps to zero, and to one
    p = plain_plan(); p.cnt = 32'h1_0000; p.esz = 32'h1_0000; run_gpt(p);
    p = plain_plan(); p.cnt = '1; p.esz = '1; run_gpt(p);
    p = plain_plan(); p.arr_delta = 2; run_gpt(p);
    p = plain_plan(); p.arr_delta = -1; run_gpt(p);
    p = plain_plan(); p.bad_acrc = 1; run_gpt(p);
    p = plain_plan(); p.hdr_len = 600; run_gpt(p);
    p = plain_plan(); p.hdr_len = SECTOR_BYTES - 1; run_gpt(p);

    write_lba(64'd0);
    p = plain_plan(); run_gpt(p);
    p = plain_plan(); p.lba = 64'd1; run_gpt(p);
    write_lba('1);
    p = plain_plan(); run_gpt(p);
    p = plain_plan(); p.lba = 64'h7FFF_FFFF_FFFF_FFFF; run_gpt(p);

    // Long result-side hold while stray bytes keep coming
    hold_long = 1'b1;
    wait (holding == 1'b1);
    send_raw(REQ_ARRAY, 12);

    base_items = sent_items;
    while (sent_items - base_items < 2000) begin
      case ($urandom_range(0, 3))
        0: write_lba(64'd0);
        1: write_lba('1);
        2: write_lba({32'd0, 32'($urandom_range(0, 64))});
        default: write_lba({$urandom, $urandom});
      endcase
      repeat (6) random_sequence();
    end

    settle(10);
    if (sb.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
